### sv/bgsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgsd_pkg: shared definitions for the bitmap group set decoder
// Holds the field widths, parameter defaults and the sequencer state type.
// ----------------------------------------------------------------------------
package bgsd_pkg;

  localparam int BASE_W = 26;
  localparam int MASK_W = 32;
  localparam int VALUE_W = 31;
  localparam int POS_W = 16;
  localparam int IDX_W = 5;

  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_LIST_CAPACITY = 65536;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } seq_state_t;

endpackage

### sv/bitmap_group_set_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_group_set_decoder_unit: expand base/mask groups into a value list
// Turns each set bit of a group's mask into one value item, lowest bit first.
// ----------------------------------------------------------------------------
// Usage:
//   Group channel (group_valid/group_ready) takes one group per item: the
//   base, the presence mask and an end-of-list flag. Value channel
//   (value_valid/value_ready) gives one item per set mask bit: the value
//   (base << log2(WORD_BITS)) | bit index, its position in the list and the
//   group_done / list_done marks.
//   Sequence: a taken group is latched into the pending mask, and its
//   first value is then loaded from there into the output register. A
//   group with n set bits gives n values, one find-lowest-set step per
//   value, all through the single mask scan unit, and a zero mask gives
//   no values.
//   The next group is taken while the last value of the previous one still
//   waits in the output register.
//   A stall on the value side holds the output register and the scan; the
//   decoder resumes the cycle the waiting value is taken.
//   Reset clears the sequencer, the pending mask, the output valid and the
//   running list position.
// ----------------------------------------------------------------------------
module bitmap_group_set_decoder_unit #(
  parameter int WORD_BITS = bgsd_pkg::DEF_WORD_BITS,
  parameter int LIST_CAPACITY = bgsd_pkg::DEF_LIST_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        group_valid,
  output logic                        group_ready,
  input  logic [bgsd_pkg::BASE_W-1:0] group_base,
  input  logic [bgsd_pkg::MASK_W-1:0] bit_mask,
  input  logic                        end_of_list,
  output logic                        value_valid,
  input  logic                        value_ready,
  output logic [bgsd_pkg::VALUE_W-1:0] set_value,
  output logic [bgsd_pkg::POS_W-1:0]  list_position,
  output logic                        group_done,
  output logic                        list_done
);
  import bgsd_pkg::*;

  // Shift is floor(log2(WORD_BITS)).
  localparam int SHIFT = $clog2(WORD_BITS + 1) - 1;
  // Mask bits at WORD_BITS and above never take part.
  localparam logic [MASK_W-1:0] SCAN_MASK = (WORD_BITS >= MASK_W) ? {MASK_W{1'b1}} :
    MASK_W'((64'd1 << WORD_BITS) - 64'd1);
  // Position saturates at the smaller of capacity-1 and the field maximum.
  localparam int LIMIT_INT = (LIST_CAPACITY - 1 > 65535) ? 65535 : LIST_CAPACITY - 1;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LIMIT_INT);

  seq_state_t state, state_next;

  logic [MASK_W-1:0] pending_mask;
  logic [BASE_W-1:0] held_base;
  logic              held_last;
  logic [POS_W-1:0]  running_position;

  logic              group_take;
  logic              out_load;
  logic [MASK_W-1:0] masked_in;
  logic [MASK_W-1:0] lowest_bit;
  logic [MASK_W-1:0] pending_next;
  logic [IDX_W-1:0]  lowest_idx;
  logic [MASK_W-1:0] base_shifted;
  logic [MASK_W-1:0] value_full;
  logic              last_of_group;

  assign group_take = group_valid && group_ready;
  assign masked_in = bit_mask & SCAN_MASK;

  // Shared scan unit: isolate the lowest set bit, encode it, drop it.
  always_comb begin
    lowest_bit = pending_mask & (~pending_mask + MASK_W'(1));
    pending_next = pending_mask & (pending_mask - MASK_W'(1));
    lowest_idx = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (lowest_bit[i]) begin
        lowest_idx = lowest_idx | IDX_W'(i);
      end
    end
    last_of_group = (pending_next == '0);
    base_shifted = {{(MASK_W - BASE_W){1'b0}}, held_base} << SHIFT;
    value_full = base_shifted | {{(MASK_W - IDX_W){1'b0}}, lowest_idx};
  end

  // Output register is free when empty or being taken this cycle.
  assign out_load = (state == ST_EMIT) && (!value_valid || value_ready);

  always_comb begin
    state_next = state;
    group_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        group_ready = 1'b1;
        if (group_valid && (masked_in != '0)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && last_of_group) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_mask <= '0;
      held_base <= '0;
      held_last <= 1'b0;
      running_position <= '0;
      value_valid <= 1'b0;
    end else begin
      if (group_take) begin
        // Latch the group; a zero mask that ends the list just clears the count.
        pending_mask <= masked_in;
        held_base <= group_base;
        held_last <= end_of_list;
        if ((masked_in == '0) && end_of_list) begin
          running_position <= '0;
        end
      end
      if (out_load) begin
        value_valid <= 1'b1;
        pending_mask <= pending_next;
        if (last_of_group && held_last) begin
          running_position <= '0;
        end else if (running_position < POS_LIMIT) begin
          running_position <= running_position + POS_W'(1);
        end else begin
          running_position <= POS_LIMIT;
        end
      end else if (value_ready) begin
        value_valid <= 1'b0;
      end
    end
  end

  // Output payload: hold while stalled, advance on each load.
  always_ff @(posedge clk) begin
    if (out_load) begin
      set_value <= value_full[VALUE_W-1:0];
      list_position <= running_position;
      group_done <= last_of_group;
      list_done <= last_of_group && held_last;
    end
  end

  // A group in flight always has bits left to emit.
  a_emit_has_bits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (pending_mask != '0))
    else $error("decoder in emit state with empty pending mask");

  // The last value of a list is also the last of its group.
  a_list_implies_group: assert property (@(posedge clk) disable iff (rst)
    (value_valid && list_done) |-> group_done)
    else $error("list_done without group_done");

  // Once the list end is out, the running position has been cleared.
  a_list_end_clears: assert property (@(posedge clk) disable iff (rst)
    (value_valid && list_done) |-> (running_position == '0))
    else $error("running position not cleared after list end");

  // Position never passes its saturation point.
  a_pos_limit: assert property (@(posedge clk) disable iff (rst)
    running_position <= POS_LIMIT)
    else $error("running position beyond limit");

endmodule
